FILE: rtl/csfam_pkg.sv
`timescale 1ns / 1ps

package csfam_pkg;

  // Fixed field widths
  localparam int COORD_W = 12;
  localparam int ADDR_W  = 26;
  localparam int CROP_W  = 14;
  localparam int SIZE_W  = 13;
  localparam int SIZE_MAX = (2 ** SIZE_W) - 1;

  // Register file geometry: eight 32-bit words
  localparam int PADDR_W   = 5;
  localparam int REG_IDX_W = 3;
  localparam int PDATA_W   = 32;

  // Reset values of the size registers
  localparam logic [SIZE_W-1:0] SRC_WIDTH_RST  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] SRC_HEIGHT_RST = SIZE_W'(480);
  localparam logic [SIZE_W-1:0] DST_WIDTH_RST  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] DST_HEIGHT_RST = SIZE_W'(480);

  // Register indexes, word address = 4 * index
  typedef enum logic [REG_IDX_W-1:0] {
    REG_CROP_TOP    = 3'd0,
    REG_CROP_BOTTOM = 3'd1,
    REG_CROP_LEFT   = 3'd2,
    REG_CROP_RIGHT  = 3'd3,
    REG_SRC_WIDTH   = 3'd4,
    REG_SRC_HEIGHT  = 3'd5,
    REG_DST_WIDTH   = 3'd6,
    REG_DST_HEIGHT  = 3'd7
  } reg_idx_t;

endpackage

FILE: rtl/crop_scale_flip_address_map.sv
// Crop, scale and vertical-flip address mapper for 24-bit RGB frames.
// Input channel (in_valid/in_ready) takes one destination pixel (dst_x, dst_y)
// per word; output channel (out_valid/out_ready) returns the source pixel it
// copies from, both byte offsets (rows padded to four bytes) and the
// copy_pixel / clear_pixel flags. Crop window and frame sizes sit in eight
// APB registers at byte address 4*i; write them only while the block is idle.
// Throughput: one word per clock while the receiver does not stall. DW =
// clog2(min(MAX_DIM, 8191)+1) sets coordinate and quotient widths. Stages:
// capture, multiply, the two restoring dividers (one quotient bit per stage,
// x and y side by side), then offset/flip, source multiply and output.
// Reset clears all valid bits and loads the register defaults (no crop,
// 640x480 source and destination). When the receiver stalls, words back up
// stage by stage; in_ready stays high while any stage holds a bubble and
// drops only once every stage is full. Nothing is dropped or repeated.
`timescale 1ns / 1ps

module crop_scale_flip_address_map
  import csfam_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  // destination pixel in
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COORD_W-1:0]   dst_x,
  input  logic [COORD_W-1:0]   dst_y,
  // mapping out
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COORD_W-1:0]   src_x,
  output logic [COORD_W-1:0]   src_y,
  output logic [ADDR_W-1:0]    src_addr,
  output logic [ADDR_W-1:0]    dst_addr,
  output logic                 copy_pixel,
  output logic                 clear_pixel
);

  // Internal widths
  localparam int EFF_DIM = (MAX_DIM < SIZE_MAX) ? MAX_DIM : SIZE_MAX;
  localparam int DW  = $clog2(EFF_DIM + 1);   // sizes, coordinates, quotients
  localparam int STW = DW + 2;                // padded row stride
  localparam int NW  = COORD_W + DW;          // dividend
  localparam int AW  = COORD_W + STW;         // destination address sum
  localparam int SAW = DW + STW;              // source address sum
  localparam int X3W = COORD_W + 2;

  typedef struct packed {
    logic [DW-1:0]     rx;
    logic [DW-1:0]     qx;
    logic [DW-1:0]     ry;
    logic [DW-1:0]     qy;
    logic [ADDR_W-1:0] daddr;
    logic              ok;
    logic              clr;
  } div_t;

  // Size register limited to MAX_DIM
  function automatic logic [DW-1:0] dim_of(input logic [SIZE_W-1:0] v);
    return (32'(v) > MAX_DIM) ? DW'(MAX_DIM) : DW'(v);
  endfunction

  // Row stride in bytes, padded to four
  function automatic logic [STW-1:0] stride_of(input logic [DW-1:0] w);
    logic [STW-1:0] t;
    t = STW'(w) * STW'(3) + STW'(3);
    return {t[STW-1:2], 2'b00};
  endfunction

  // One crop axis: {low bound, extent}
  function automatic logic [2*DW-1:0] axis_win(input logic [CROP_W-1:0] a,
                                               input logic [CROP_W-1:0] b,
                                               input logic [DW-1:0]     full);
    logic signed [CROP_W:0] sa, sb, lo, hi, fs;
    logic [DW-1:0]          lo_c, hi_c;
    sa = (CROP_W+1)'($signed(a));
    sb = (CROP_W+1)'($signed(b));
    fs = $signed({1'b0, CROP_W'(full)});
    lo = (sa < sb) ? sa : sb;
    hi = (sa < sb) ? sb : sa;
    if (lo < 0) lo = '0;
    else if (lo > fs) lo = fs;
    if (hi < 0) hi = '0;
    else if (hi > fs) hi = fs;
    lo_c = DW'(lo);
    hi_c = DW'(hi);
    if (a == '0 && b == '0) begin
      return {{DW{1'b0}}, full};
    end
    return {lo_c, DW'(hi_c - lo_c)};
  endfunction

  // ---------------- configuration registers ----------------
  logic [CROP_W-1:0] crop_top, crop_bottom, crop_left, crop_right;
  logic [SIZE_W-1:0] src_width, src_height, dst_width, dst_height;
  reg_idx_t          cfg_idx;
  logic              cfg_wr;

  assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crop_top    <= '0;
      crop_bottom <= '0;
      crop_left   <= '0;
      crop_right  <= '0;
      src_width   <= SRC_WIDTH_RST;
      src_height  <= SRC_HEIGHT_RST;
      dst_width   <= DST_WIDTH_RST;
      dst_height  <= DST_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CROP_TOP:    crop_top    <= pwdata[CROP_W-1:0];
        REG_CROP_BOTTOM: crop_bottom <= pwdata[CROP_W-1:0];
        REG_CROP_LEFT:   crop_left   <= pwdata[CROP_W-1:0];
        REG_CROP_RIGHT:  crop_right  <= pwdata[CROP_W-1:0];
        REG_SRC_WIDTH:   src_width   <= pwdata[SIZE_W-1:0];
        REG_SRC_HEIGHT:  src_height  <= pwdata[SIZE_W-1:0];
        REG_DST_WIDTH:   dst_width   <= pwdata[SIZE_W-1:0];
        REG_DST_HEIGHT:  dst_height  <= pwdata[SIZE_W-1:0];
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (cfg_idx)
      REG_CROP_TOP:    prdata = PDATA_W'(crop_top);
      REG_CROP_BOTTOM: prdata = PDATA_W'(crop_bottom);
      REG_CROP_LEFT:   prdata = PDATA_W'(crop_left);
      REG_CROP_RIGHT:  prdata = PDATA_W'(crop_right);
      REG_SRC_WIDTH:   prdata = PDATA_W'(src_width);
      REG_SRC_HEIGHT:  prdata = PDATA_W'(src_height);
      REG_DST_WIDTH:   prdata = PDATA_W'(dst_width);
      REG_DST_HEIGHT:  prdata = PDATA_W'(dst_height);
    endcase
  end

  // ---------------- derived window terms, one register stage ----------------
  logic [DW-1:0]  ws, hs;
  logic [2*DW-1:0] win_x, win_y;
  logic [DW-1:0]  cfg_left, cfg_rw, cfg_rh, cfg_wd, cfg_hd, cfg_ybase;
  logic [STW-1:0] cfg_stride_s, cfg_stride_d;
  logic           cfg_empty;

  always_comb begin
    ws    = dim_of(src_width);
    hs    = dim_of(src_height);
    win_x = axis_win(crop_left, crop_right, ws);
    win_y = axis_win(crop_top, crop_bottom, hs);
  end

  always_ff @(posedge clk) begin
    cfg_left     <= win_x[2*DW-1:DW];
    cfg_rw       <= win_x[DW-1:0];
    cfg_rh       <= win_y[DW-1:0];
    // flipped row base: hs - 1 - top, meaningful for a nonempty crop
    cfg_ybase    <= DW'(hs - DW'(1) - win_y[2*DW-1:DW]);
    cfg_empty    <= (win_x[DW-1:0] == '0) || (win_y[DW-1:0] == '0);
    cfg_wd       <= dim_of(dst_width);
    cfg_hd       <= dim_of(dst_height);
    cfg_stride_s <= stride_of(ws);
    cfg_stride_d <= stride_of(dim_of(dst_width));
  end

  // ---------------- stage handshake chain ----------------
  logic          s1_valid, s2_valid, s3_valid, s4_valid;
  logic          en1, en2, en3, en4, en_out;
  logic [DW-1:0] dv, dvin, den;

  assign en_out   = !out_valid || out_ready;
  assign en4      = !s4_valid || en_out;
  assign en3      = !s3_valid || en4;
  assign en2      = !s2_valid || den[0];
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  // ---------------- stage 1: capture coordinates ----------------
  logic [COORD_W-1:0] s1_dx, s1_dy;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en1) s1_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1_dx <= dst_x;
      s1_dy <= dst_y;
    end
  end

  // ---------------- stage 2: dividends and destination row offset ----------------
  logic [NW-1:0]  s2_nx, s2_ny;
  logic [AW-1:0]  s2_dyp;
  logic [X3W-1:0] s2_dx3;
  logic           s2_ok, s2_clr;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (en2) s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid) begin
      s2_nx  <= NW'(s1_dx) * NW'(cfg_rw);
      s2_ny  <= NW'(s1_dy) * NW'(cfg_rh);
      s2_dyp <= AW'(s1_dy) * AW'(cfg_stride_d);
      s2_dx3 <= X3W'(s1_dx) * X3W'(3);
      s2_ok  <= (32'(s1_dx) < 32'(cfg_wd)) && (32'(s1_dy) < 32'(cfg_hd));
      s2_clr <= cfg_empty;
    end
  end

  // ---------------- divider pipeline: one quotient bit per stage ----------------
  // For in-frame pixels the quotient is below the crop extent, so DW bits suffice
  // and the upper dividend bits start below the divisor.
  div_t dinit;
  div_t dsrc [DW];
  div_t dnxt [DW];
  div_t dreg [DW];

  always_comb begin
    dinit.rx    = DW'(s2_nx >> DW);
    dinit.qx    = s2_nx[DW-1:0];
    dinit.ry    = DW'(s2_ny >> DW);
    dinit.qy    = s2_ny[DW-1:0];
    dinit.daddr = ADDR_W'(s2_dyp + AW'(s2_dx3));
    dinit.ok    = s2_ok;
    dinit.clr   = s2_clr;
  end

  for (genvar k = 0; k < DW; k++) begin : g_div
    logic [DW:0] tx, ty;
    logic        gex, gey;

    if (k == 0) begin : g_first
      assign dsrc[k] = dinit;
      assign dvin[k] = s2_valid;
    end else begin : g_next
      assign dsrc[k] = dreg[k-1];
      assign dvin[k] = dv[k-1];
    end

    if (k == DW - 1) begin : g_last
      assign den[k] = !dv[k] || en3;
    end else begin : g_mid
      assign den[k] = !dv[k] || den[k+1];
    end

    // compare-subtract on both axes
    always_comb begin
      tx  = {dsrc[k].rx, dsrc[k].qx[DW-1]};
      ty  = {dsrc[k].ry, dsrc[k].qy[DW-1]};
      gex = tx >= {1'b0, cfg_wd};
      gey = ty >= {1'b0, cfg_hd};
      dnxt[k]    = dsrc[k];
      dnxt[k].rx = gex ? DW'(tx - {1'b0, cfg_wd}) : tx[DW-1:0];
      dnxt[k].qx = {dsrc[k].qx[DW-2:0], gex};
      dnxt[k].ry = gey ? DW'(ty - {1'b0, cfg_hd}) : ty[DW-1:0];
      dnxt[k].qy = {dsrc[k].qy[DW-2:0], gey};
    end

    always_ff @(posedge clk) begin
      if (rst) dv[k] <= 1'b0;
      else if (den[k]) dv[k] <= dvin[k];
    end

    always_ff @(posedge clk) begin
      if (den[k] && dvin[k]) dreg[k] <= dnxt[k];
    end
  end

  // ---------------- stage 3: offset and flip ----------------
  logic [DW-1:0]     s3_xs, s3_ys;
  logic [ADDR_W-1:0] s3_daddr;
  logic              s3_ok, s3_clr;

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (en3) s3_valid <= dv[DW-1];
  end

  always_ff @(posedge clk) begin
    if (en3 && dv[DW-1]) begin
      s3_xs    <= DW'(dreg[DW-1].qx + cfg_left);
      s3_ys    <= DW'(cfg_ybase - dreg[DW-1].qy);
      s3_daddr <= dreg[DW-1].daddr;
      s3_ok    <= dreg[DW-1].ok;
      s3_clr   <= dreg[DW-1].clr;
    end
  end

  // ---------------- stage 4: source row offset ----------------
  logic [SAW-1:0]    s4_prod;
  logic [DW+1:0]     s4_x3;
  logic [DW-1:0]     s4_xs, s4_ys;
  logic [ADDR_W-1:0] s4_daddr;
  logic              s4_ok, s4_clr;

  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else if (en4) s4_valid <= s3_valid;
  end

  always_ff @(posedge clk) begin
    if (en4 && s3_valid) begin
      s4_prod  <= SAW'(s3_ys) * SAW'(cfg_stride_s);
      s4_x3    <= (DW+2)'(s3_xs) * (DW+2)'(3);
      s4_xs    <= s3_xs;
      s4_ys    <= s3_ys;
      s4_daddr <= s3_daddr;
      s4_ok    <= s3_ok;
      s4_clr   <= s3_clr;
    end
  end

  // ---------------- output register ----------------
  logic s4_copy;
  assign s4_copy = s4_ok && !s4_clr;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en_out) out_valid <= s4_valid;
  end

  always_ff @(posedge clk) begin
    if (en_out && s4_valid) begin
      src_x       <= s4_copy ? COORD_W'(s4_xs) : '0;
      src_y       <= s4_copy ? COORD_W'(s4_ys) : '0;
      src_addr    <= s4_copy ? ADDR_W'(s4_prod + SAW'(s4_x3)) : '0;
      dst_addr    <= s4_ok ? s4_daddr : '0;
      copy_pixel  <= s4_copy;
      clear_pixel <= s4_ok && s4_clr;
    end
  end

  // ---------------- checks ----------------
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(copy_pixel && clear_pixel))
    else $error("copy and clear both set");

  a_nocopy_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !copy_pixel) |-> (src_x == '0 && src_y == '0 && src_addr == '0))
    else $error("source fields not zero without copy");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input blocked while output not stalled");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !copy_pixel && !clear_pixel) |-> (dst_addr == '0))
    else $error("destination address set outside frame");

endmodule

FILE: dv/csfam_checker.sv
`timescale 1ns / 1ps

module csfam_checker
  import csfam_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic               clk,
  input  logic               rst,
  // configuration port, watched only
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  // destination pixel in
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [COORD_W-1:0] dst_x,
  input  logic [COORD_W-1:0] dst_y,
  // mapping out
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [COORD_W-1:0] src_x,
  input  logic [COORD_W-1:0] src_y,
  input  logic [ADDR_W-1:0]  src_addr,
  input  logic [ADDR_W-1:0]  dst_addr,
  input  logic               copy_pixel,
  input  logic               clear_pixel,
  output int                 mismatches,
  output int                 maps_owed
);

  typedef struct packed {
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [ADDR_W-1:0]  saddr;
    logic [ADDR_W-1:0]  daddr;
    logic               copy;
    logic               clear;
  } pixel_map_t;

  // shadow of the register file
  logic signed [CROP_W-1:0] crop_top_r, crop_bottom_r, crop_left_r, crop_right_r;
  logic [SIZE_W-1:0]        src_w_r, src_h_r, dst_w_r, dst_h_r;

  pixel_map_t owed_q[$];

  // sizes above MAX_DIM saturate
  function automatic longint eff_size(logic [SIZE_W-1:0] v);
    return (v > MAX_DIM) ? longint'(MAX_DIM) : longint'(v);
  endfunction

  function automatic longint clamp_to(longint v, longint hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // crop window on one axis: ordered, clamped bounds, or the full axis
  function automatic void crop_span(logic signed [CROP_W-1:0] a, logic signed [CROP_W-1:0] b,
                                    longint full, output longint lo, output longint len);
    longint sa, sb, l, h;
    sa = a;
    sb = b;
    if (sa != 0 || sb != 0) begin
      l = (sa < sb) ? sa : sb;
      h = (sa < sb) ? sb : sa;
      l = clamp_to(l, full);
      h = clamp_to(h, full);
      lo = l;
      len = h - l;
    end else begin
      lo = 0;
      len = full;
    end
  endfunction

  // 3 bytes per pixel, row padded to 4 bytes
  function automatic longint row_stride(longint w);
    return (w * 3 + 3) & ~longint'(3);
  endfunction

  function automatic pixel_map_t map_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    longint dx, dy, ws, hs, wd, hd, left, rw, top, rh, xs, ys;
    pixel_map_t m;
    m = '0;
    dx = x;
    dy = y;
    ws = eff_size(src_w_r);
    hs = eff_size(src_h_r);
    wd = eff_size(dst_w_r);
    hd = eff_size(dst_h_r);
    crop_span(crop_left_r, crop_right_r, ws, left, rw);
    crop_span(crop_top_r, crop_bottom_r, hs, top, rh);
    if (dx < wd && dy < hd) begin
      m.daddr = ADDR_W'(dy * row_stride(wd) + dx * 3);
      if (rw == 0 || rh == 0) begin
        m.clear = 1'b1;
      end else begin
        xs = dx * rw / wd + left;
        ys = hs - 1 - (dy * rh / hd + top);
        if (xs >= 0 && xs < ws && ys >= 0 && ys < hs) begin
          m.sx = COORD_W'(xs);
          m.sy = COORD_W'(ys);
          m.saddr = ADDR_W'(ys * row_stride(ws) + xs * 3);
          m.copy = 1'b1;
        end
      end
    end
    return m;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // track config, queue a mapping per input word, compare per output word
  always @(posedge clk) begin
    pixel_map_t want;
    if (rst) begin
      crop_top_r    <= '0;
      crop_bottom_r <= '0;
      crop_left_r   <= '0;
      crop_right_r  <= '0;
      src_w_r       <= SRC_WIDTH_RST;
      src_h_r       <= SRC_HEIGHT_RST;
      dst_w_r       <= DST_WIDTH_RST;
      dst_h_r       <= DST_HEIGHT_RST;
      owed_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[PADDR_W-1:2]))
          REG_CROP_TOP:    crop_top_r    <= pwdata[CROP_W-1:0];
          REG_CROP_BOTTOM: crop_bottom_r <= pwdata[CROP_W-1:0];
          REG_CROP_LEFT:   crop_left_r   <= pwdata[CROP_W-1:0];
          REG_CROP_RIGHT:  crop_right_r  <= pwdata[CROP_W-1:0];
          REG_SRC_WIDTH:   src_w_r       <= pwdata[SIZE_W-1:0];
          REG_SRC_HEIGHT:  src_h_r       <= pwdata[SIZE_W-1:0];
          REG_DST_WIDTH:   dst_w_r       <= pwdata[SIZE_W-1:0];
          REG_DST_HEIGHT:  dst_h_r       <= pwdata[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) owed_q.push_back(map_pixel(dst_x, dst_y));
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          report_mismatch("output word with no mapping owed");
        end else begin
          want = owed_q.pop_front();
          check_field("src_x", src_x, want.sx);
          check_field("src_y", src_y, want.sy);
          check_field("src_addr", src_addr, want.saddr);
          check_field("dst_addr", dst_addr, want.daddr);
          check_field("copy_pixel", copy_pixel, want.copy);
          check_field("clear_pixel", clear_pixel, want.clear);
        end
      end
    end
    maps_owed <= owed_q.size();
  end

endmodule

FILE: dv/crop_scale_flip_address_map_tb.sv
`timescale 1ns / 1ps

module crop_scale_flip_address_map_tb;
  import csfam_pkg::*;

  localparam int MAX_DIM     = 4096;
  localparam int RANDOM_WORDS = 1450;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 24;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [COORD_W-1:0] dst_x = '0;
  logic [COORD_W-1:0] dst_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [COORD_W-1:0] src_x;
  logic [COORD_W-1:0] src_y;
  logic [ADDR_W-1:0]  src_addr;
  logic [ADDR_W-1:0]  dst_addr;
  logic               copy_pixel;
  logic               clear_pixel;

  int  mismatches;
  int  maps_owed;
  int  cycles = 0;
  int  random_sent = 0;
  int  cur_dw = 640;
  int  cur_dh = 480;
  logic calm = 1'b0;

  crop_scale_flip_address_map #(.MAX_DIM(MAX_DIM)) u_dut (.*);

  csfam_checker #(.MAX_DIM(MAX_DIM)) u_check (.*);

  always #5 clk = ~clk;

  // hard stop
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("crop_scale_flip_address_map_tb: errors");
      $finish;
    end
  end

  // receiver stalls about 21% of cycles, none while calm
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 21);
  end

  function automatic int eff_size(int v);
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

  task automatic write_reg(reg_idx_t idx, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(int top, int bottom, int left, int right,
                           int sw, int sh, int dw, int dh);
    write_reg(REG_CROP_TOP, top);
    write_reg(REG_CROP_BOTTOM, bottom);
    write_reg(REG_CROP_LEFT, left);
    write_reg(REG_CROP_RIGHT, right);
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    cur_dw = dw;
    cur_dh = dh;
  endtask

  // one pixel word; valid stays up across back-to-back words
  task automatic send_word(int x, int y);
    while (!calm && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    dst_x    <= COORD_W'(x);
    dst_y    <= COORD_W'(y);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // wait until every mapping is back, then let the pipe go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (maps_owed != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // mostly inside the destination, with edges and full-range noise
  task automatic random_word();
    int ew, eh, r;
    ew = eff_size(cur_dw);
    eh = eff_size(cur_dh);
    r  = $urandom_range(0, 99);
    if (ew == 0 || eh == 0 || r < 12)
      send_word($urandom_range(0, 4095), $urandom_range(0, 4095));
    else if (r < 20)
      send_word((ew - 1 + $urandom_range(0, 1)) % 4096, $urandom_range(0, eh - 1));
    else if (r < 26)
      send_word($urandom_range(0, ew - 1), (eh - 1 + $urandom_range(0, 1)) % 4096);
    else
      send_word($urandom_range(0, ew - 1), $urandom_range(0, eh - 1));
    random_sent++;
  endtask

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)  return 0;
    if (r < 8)  return $urandom_range(MAX_DIM + 1, 8191);
    if (r < 12) return MAX_DIM;
    if (r < 18) return 1;
    if (r < 60) return $urandom_range(2, 64);
    return $urandom_range(65, MAX_DIM);
  endfunction

  // crop bound pair: none, empty, wild, one-sided, or inside the source
  task automatic pick_bounds(int full, output int a, output int b);
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      a = 0;
      b = 0;
    end else if (r < 35) begin
      a = int'($urandom_range(0, 16383)) - 8192;
      if (a == 0) a = 1;
      b = a;
    end else if (r < 45) begin
      a = int'($urandom_range(0, 16383)) - 8192;
      b = int'($urandom_range(0, 16383)) - 8192;
    end else if (r < 52) begin
      a = 0;
      b = $urandom_range(0, full);
    end else begin
      a = $urandom_range(0, full);
      b = $urandom_range(0, full);
    end
  endtask

  initial begin
    int sw, sh, dw, dh, t, b, l, r, phase, n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset frame: corners, just outside, full-range coordinates
    send_word(0, 0);
    send_word(639, 479);
    send_word(640, 0);
    send_word(0, 480);
    send_word(4095, 4095);
    send_word(320, 240);
    settle();

    // reversed and partly negative bounds, downscale
    set_frame(400, 100, 500, -20, 640, 480, 100, 50);
    send_word(0, 0);
    send_word(99, 49);
    send_word(50, 25);
    send_word(100, 49);
    settle();

    // equal nonzero row bounds: empty crop, clear
    set_frame(7, 7, 0, 0, 640, 480, 640, 480);
    send_word(0, 0);
    send_word(639, 479);
    send_word(640, 479);
    settle();

    // oversized sizes saturate, extreme crop bounds clamp to full axis
    set_frame(-8192, 8191, 8191, -8192, 8191, 8191, 8191, 8191);
    send_word(4095, 4095);
    send_word(0, 0);
    send_word(4095, 0);
    send_word(0, 4095);
    settle();

    // zero source width empties the crop
    set_frame(0, 0, 0, 0, 0, 480, 5, 5);
    send_word(0, 0);
    send_word(4, 4);
    send_word(5, 0);
    settle();

    // zero destination size: everything outside
    set_frame(0, 0, 0, 0, 640, 480, 0, 480);
    send_word(0, 0);
    settle();

    // single-pixel source blown up to the largest destination
    set_frame(0, 0, 0, 0, 1, 1, MAX_DIM, MAX_DIM);
    send_word(4095, 4095);
    settle();

    // random frames, one long stall-free phase
    phase = 0;
    while (random_sent < RANDOM_WORDS) begin
      sw = pick_size();
      sh = pick_size();
      dw = pick_size();
      dh = pick_size();
      pick_bounds(eff_size(sw), l, r);
      pick_bounds(eff_size(sh), t, b);
      set_frame(t, b, l, r, sw, sh, dw, dh);
      calm <= (phase == 4);
      n = (phase == 4) ? 250 : $urandom_range(15, 50);
      repeat (n) random_word();
      settle();
      phase++;
    end

    if (mismatches == 0)
      $display("crop_scale_flip_address_map_tb: clean");
    else
      $display("crop_scale_flip_address_map_tb: errors");
    $finish;
  end

endmodule

FILE: sim.f
rtl/csfam_pkg.sv
rtl/crop_scale_flip_address_map.sv
dv/csfam_checker.sv
dv/crop_scale_flip_address_map_tb.sv
